// ===== design/ata_pkg.sv =====
// Shared widths, constants and the CORDIC angle table for the tilt angle block.
package ata_pkg;

    localparam int AXIS_W     = 16;
    localparam int SQ_W       = 31;
    localparam int SUM_W      = 32;
    localparam int RAD_W      = 48;
    localparam int ROOT_W     = 24;
    localparam int REM_W      = 27;
    localparam int CV_W       = 27;
    localparam int ANG_W      = 33;
    localparam int OUT_W      = 14;
    localparam int TAB_LEN    = 24;
    localparam int TAB_FRAC   = 24;
    localparam int ANGLE_FRAC_BITS_DEF = 6;
    localparam int CORDIC_STEPS_DEF    = 16;

    // Sideband carried down the pipeline next to the arithmetic
    typedef struct packed {
        logic                     valid;
        logic                     zero;
        logic signed [AXIS_W-1:0] ax;
        logic signed [AXIS_W-1:0] ay;
        logic signed [AXIS_W-1:0] az;
    } ata_side_t;

    // atan(2^-i) in degrees, scaled by 2^24 and rounded
    function automatic logic signed [ANG_W-1:0] atan_tab(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 33'sd754974720;
            5'd1:    v = 33'sd445687602;
            5'd2:    v = 33'sd235489088;
            5'd3:    v = 33'sd119537938;
            5'd4:    v = 33'sd60000934;
            5'd5:    v = 33'sd30029717;
            5'd6:    v = 33'sd15018523;
            5'd7:    v = 33'sd7509720;
            5'd8:    v = 33'sd3754917;
            5'd9:    v = 33'sd1877466;
            5'd10:   v = 33'sd938734;
            5'd11:   v = 33'sd469367;
            5'd12:   v = 33'sd234684;
            5'd13:   v = 33'sd117342;
            5'd14:   v = 33'sd58671;
            5'd15:   v = 33'sd29335;
            5'd16:   v = 33'sd14668;
            5'd17:   v = 33'sd7334;
            5'd18:   v = 33'sd3667;
            5'd19:   v = 33'sd1833;
            5'd20:   v = 33'sd917;
            5'd21:   v = 33'sd458;
            5'd22:   v = 33'sd229;
            5'd23:   v = 33'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/ata_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module ata_isqrt (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [ata_pkg::RAD_W-1:0]  rad,
    output logic [ata_pkg::ROOT_W-1:0] root
);
    import ata_pkg::*;

    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    genvar i;
    generate
        for (i = 0; i < ROOT_W; i++) begin : g_stage
            logic [RAD_W-1:0]  rad_in;
            logic [REM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [REM_W-1:0]  rem_sh;
            logic [REM_W-1:0]  trial;

            if (i == 0) begin : g_first
                assign rad_in  = rad;
                assign rem_in  = '0;
                assign root_in = '0;
            end else begin : g_next
                assign rad_in  = rad_reg[i-1];
                assign rem_in  = rem_reg[i-1];
                assign root_in = root_reg[i-1];
            end

            // Bring down the next two radicand bits and try a one bit
            assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
            assign trial  = {1'b0, root_in, 2'b01};

            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[i] <= {rad_in[RAD_W-3:0], 2'b00};
                    if (rem_sh >= trial) begin
                        rem_reg[i]  <= rem_sh - trial;
                        root_reg[i] <= {root_in[ROOT_W-2:0], 1'b1};
                    end else begin
                        rem_reg[i]  <= rem_sh;
                        root_reg[i] <= {root_in[ROOT_W-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign root = root_reg[ROOT_W-1];

endmodule

// ===== design/ata_cordic.sv =====
// Pipelined vectoring CORDIC lane, one micro-rotation per stage.
module ata_cordic #(
    parameter int STEPS = ata_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [ata_pkg::CV_W-1:0]  a,
    input  logic signed [ata_pkg::CV_W-1:0]  b,
    output logic signed [ata_pkg::ANG_W-1:0] angle
);
    import ata_pkg::*;

    localparam int N = (STEPS < TAB_LEN) ? STEPS : TAB_LEN;

    logic signed [CV_W-1:0]  x_reg [N];
    logic signed [CV_W-1:0]  y_reg [N];
    logic signed [ANG_W-1:0] z_reg [N];

    genvar i;
    generate
        for (i = 0; i < N; i++) begin : g_rot
            logic signed [CV_W-1:0]  x_in;
            logic signed [CV_W-1:0]  y_in;
            logic signed [ANG_W-1:0] z_in;
            logic signed [CV_W-1:0]  sx;
            logic signed [CV_W-1:0]  sy;
            logic signed [ANG_W-1:0] t;

            if (i == 0) begin : g_first
                assign x_in = b;
                assign y_in = a;
                assign z_in = '0;
            end else begin : g_next
                assign x_in = x_reg[i-1];
                assign y_in = y_reg[i-1];
                assign z_in = z_reg[i-1];
            end

            assign sx = x_in >>> i;
            assign sy = y_in >>> i;
            assign t  = atan_tab(5'(i));

            // Rotate toward the x axis and accumulate the angle
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (!y_in[CV_W-1]) begin
                        x_reg[i] <= x_in + sy;
                        y_reg[i] <= y_in - sx;
                        z_reg[i] <= z_in + t;
                    end else begin
                        x_reg[i] <= x_in - sy;
                        y_reg[i] <= y_in + sx;
                        z_reg[i] <= z_in - t;
                    end
                end
            end
        end
    endgenerate

    assign angle = z_reg[N-1];

endmodule

// ===== design/accel_tilt_angles.sv =====
// Top level: accelerometer tilt angles from three parallel CORDIC lanes.
//
// Input transaction: one accelerometer sample (x, y, z) on the s_ channel.
// Output transaction: tilt_x, tilt_y (asin, -90..90 deg) and tilt_z
// (acos, 0..180 deg) in units of 2^-ANGLE_FRAC_BITS degree, with a
// zero_vector flag in m_tuser that marks an all-zero sample (angles 0).
// Three square-root lanes form the radial terms, three CORDIC lanes turn
// them into angles, and a merging stage rounds, saturates and folds the
// z angle for negative z.
// Stages from the accepting edge to m_tvalid: square (loaded at the
// accepting edge), sum, one stage per root bit, one stage per rotation,
// output register.
// Throughput: one sample per cycle unless stalled; every stage is fully pipelined.
// Stall: when the output is valid and not taken, the whole pipeline holds
// and s_tready drops in the same cycle; nothing is lost or repeated.
// Reset: synchronous aresetn clears all valid bits; data is not cleared.
module accel_tilt_angles #(
    parameter int ANGLE_FRAC_BITS = ata_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = ata_pkg::CORDIC_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // tilt_x[13:0], tilt_y[27:14], tilt_z[41:28], [47:42] zero
    output logic        m_tuser    // zero_vector[0]
);
    import ata_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
    localparam int LAST  = 1 + ROOT_W + NSTEP;
    localparam int SHIFT = TAB_FRAC - ANGLE_FRAC_BITS;
    localparam int RW    = ANG_W + 1;
    localparam logic signed [RW-1:0] HALF   = RW'(1) <<< (SHIFT - 1);
    localparam logic signed [RW-1:0] DEG90  = RW'(90) <<< ANGLE_FRAC_BITS;
    localparam logic signed [RW-1:0] DEG180 = RW'(180) <<< ANGLE_FRAC_BITS;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Sideband line
    ata_side_t side_reg [LAST+1];
    ata_side_t side_in;
    assign side_in.valid = s_tvalid;
    assign side_in.ax    = s_tdata[15:0];
    assign side_in.ay    = s_tdata[31:16];
    assign side_in.az    = s_tdata[47:32];
    assign side_in.zero  = (s_tdata == '0);

    genvar k;
    generate
        for (k = 0; k <= LAST; k++) begin : g_side
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    side_reg[k].valid <= 1'b0;
                end else if (en) begin
                    if (k == 0) side_reg[k] <= side_in;
                    else        side_reg[k] <= side_reg[k == 0 ? 0 : k-1];
                end
            end
        end
    endgenerate

    // Square each axis and sum the pairs
    logic [SQ_W-1:0]  sqx_reg, sqy_reg, sqz_reg;
    logic [SUM_W-1:0] sum_yz_reg, sum_xz_reg, sum_xy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg <= SQ_W'($signed(side_in.ax) * $signed(side_in.ax));
            sqy_reg <= SQ_W'($signed(side_in.ay) * $signed(side_in.ay));
            sqz_reg <= SQ_W'($signed(side_in.az) * $signed(side_in.az));
            sum_yz_reg <= {1'b0, sqy_reg} + {1'b0, sqz_reg};
            sum_xz_reg <= {1'b0, sqx_reg} + {1'b0, sqz_reg};
            sum_xy_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        end
    end

    // Radial terms
    logic [ROOT_W-1:0] r_yz, r_xz, r_xy;

    ata_isqrt u_sqrt_yz (.aclk(aclk), .en(en), .rad({sum_yz_reg, 16'h0}), .root(r_yz));
    ata_isqrt u_sqrt_xz (.aclk(aclk), .en(en), .rad({sum_xz_reg, 16'h0}), .root(r_xz));
    ata_isqrt u_sqrt_xy (.aclk(aclk), .en(en), .rad({sum_xy_reg, 16'h0}), .root(r_xy));

    // Lane operands, aligned with the sideband at the root outputs
    ata_side_t              mid;
    logic signed [CV_W-1:0] a_x, b_x, a_y, b_y, a_z, b_z;
    logic signed [CV_W-1:0] az_ext;

    assign mid    = side_reg[1 + ROOT_W];
    assign az_ext = CV_W'(mid.az);
    assign a_x    = CV_W'(mid.ax) <<< 8;
    assign b_x    = $signed({3'b000, r_yz});
    assign a_y    = CV_W'(mid.ay) <<< 8;
    assign b_y    = $signed({3'b000, r_xz});
    assign a_z    = $signed({3'b000, r_xy});
    assign b_z    = (mid.az[AXIS_W-1] ? -az_ext : az_ext) <<< 8;

    logic signed [ANG_W-1:0] ang_x, ang_y, ang_z;

    ata_cordic #(.STEPS(CORDIC_STEPS)) u_lane_x (.aclk(aclk), .en(en), .a(a_x), .b(b_x),
                                                 .angle(ang_x));
    ata_cordic #(.STEPS(CORDIC_STEPS)) u_lane_y (.aclk(aclk), .en(en), .a(a_y), .b(b_y),
                                                 .angle(ang_y));
    ata_cordic #(.STEPS(CORDIC_STEPS)) u_lane_z (.aclk(aclk), .en(en), .a(a_z), .b(b_z),
                                                 .angle(ang_z));

    // Merge: round, saturate, fold the z angle
    ata_side_t              fin;
    logic signed [RW-1:0]   rx, ry, rz, sx, sy, sz, tz;

    assign fin = side_reg[LAST];
    assign rx  = (RW'(ang_x) + HALF) >>> SHIFT;
    assign ry  = (RW'(ang_y) + HALF) >>> SHIFT;
    assign rz  = (RW'(ang_z) + HALF) >>> SHIFT;
    assign sx  = (rx < -DEG90) ? -DEG90 : ((rx > DEG90) ? DEG90 : rx);
    assign sy  = (ry < -DEG90) ? -DEG90 : ((ry > DEG90) ? DEG90 : ry);
    assign sz  = (rz < 0) ? RW'(0) : ((rz > DEG180) ? DEG180 : rz);
    assign tz  = fin.az[AXIS_W-1] ? DEG180 - sz : sz;

    logic               m_tvalid_reg;
    logic [OUT_W-1:0]   tilt_x_reg, tilt_y_reg, tilt_z_reg;
    logic               zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= fin.valid;
        end
        if (en) begin
            zero_reg   <= fin.zero;
            tilt_x_reg <= fin.zero ? '0 : sx[OUT_W-1:0];
            tilt_y_reg <= fin.zero ? '0 : sy[OUT_W-1:0];
            tilt_z_reg <= fin.zero ? '0 : tz[OUT_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, tilt_z_reg, tilt_y_reg, tilt_x_reg};
    assign m_tuser  = zero_reg;

endmodule
